// ----- hdl/rlbd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the RLE / back-reference byte decompressor.
// No dependencies.
package rlbd_pkg;

    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 7;
    localparam int BW_W       = 24;
    localparam int HIST_AW    = 8;
    localparam int MODE_SHIFT = 6;
    localparam int LIT_CNT_W  = 6;   // count field of literal and copy commands (0x3F)
    localparam int ST_W       = 3;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [BW_W-1:0] LIMIT_RESET = 24'hFF_FFFF;

    // register index, taken from paddr above the word offset
    localparam logic [ADDR_W-3:0] REG_OUTPUT_LIMIT = '0;

    // top two bits of a control byte
    localparam logic [1:0] MODE_LIT  = 2'd2;
    localparam logic [1:0] MODE_COPY = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_DATA  = 3'd0;
    localparam logic [ST_W-1:0] ST_END   = 3'd1;
    localparam logic [ST_W-1:0] ST_SHORT = 3'd2;
    localparam logic [ST_W-1:0] ST_LIMIT = 3'd3;
    localparam logic [ST_W-1:0] ST_DIST  = 3'd4;

    typedef enum logic [2:0] {
        OP_END   = 3'd0,
        OP_SHORT = 3'd1,
        OP_LIT   = 3'd2,
        OP_RUN   = 3'd3,
        OP_COPY  = 3'd4
    } t_op_kind;

    // one decoded command; data is the literal, run value or distance
    typedef struct packed {
        t_op_kind              kind;
        logic [BYTE_W-1:0]     data;
        logic [CNT_W-1:0]      count;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

// ----- hdl/rlbd_front.sv -----
`timescale 1ns / 1ps
// Front end: takes compressed bytes, parses command structure, pushes commands.
// Depends on rlbd_pkg.
module rlbd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rlbd_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_last,
    input  rlbd_pkg::t_fifo_status        i_fifo,
    output logic                          o_push,
    output rlbd_pkg::t_op                 o_op
);

    typedef enum logic [3:0] {
        PH_CTRL = 4'b0001,
        PH_OPER = 4'b0010,
        PH_LIT  = 4'b0100,
        PH_STOP = 4'b1000
    } t_phase;

    t_phase                         r_phase, n_phase;
    logic [1:0]                     r_mode, n_mode;
    logic [rlbd_pkg::CNT_W-1:0]     r_rem, n_rem;
    logic                           accept;

    // stopped stream swallows everything
    assign o_ready = (r_phase == PH_STOP) || !i_fifo.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_phase      = r_phase;
        n_mode       = r_mode;
        n_rem        = r_rem;
        o_push       = 1'b0;
        o_op.kind    = rlbd_pkg::OP_LIT;
        o_op.data    = i_byte;
        o_op.count   = r_rem;
        if (accept && r_phase != PH_STOP) begin
            if (r_phase == PH_CTRL && i_byte == '0) begin
                o_push    = 1'b1;
                o_op.kind = rlbd_pkg::OP_END;
                n_phase   = PH_STOP;
            end else if (i_last) begin
                o_push    = 1'b1;
                o_op.kind = rlbd_pkg::OP_SHORT;
                n_phase   = PH_STOP;
            end else begin
                unique case (r_phase)
                    PH_CTRL: begin
                        n_mode = i_byte[rlbd_pkg::BYTE_W-1:rlbd_pkg::MODE_SHIFT];
                        if (n_mode == rlbd_pkg::MODE_LIT) begin
                            n_rem = rlbd_pkg::CNT_W'(i_byte[rlbd_pkg::LIT_CNT_W-1:0]);
                            if (n_rem != '0) begin
                                n_phase = PH_LIT;
                            end
                        end else if (n_mode == rlbd_pkg::MODE_COPY) begin
                            n_rem   = rlbd_pkg::CNT_W'(i_byte[rlbd_pkg::LIT_CNT_W-1:0]);
                            n_phase = PH_OPER;
                        end else begin
                            n_rem   = i_byte[rlbd_pkg::CNT_W-1:0];
                            n_phase = PH_OPER;
                        end
                    end
                    PH_LIT: begin
                        o_push = 1'b1;
                        n_rem  = r_rem - 1'b1;
                        if (n_rem == '0) begin
                            n_phase = PH_CTRL;
                        end
                    end
                    PH_OPER: begin
                        if (r_mode == rlbd_pkg::MODE_COPY) begin
                            o_push    = (r_rem != '0);
                            o_op.kind = rlbd_pkg::OP_COPY;
                        end else begin
                            o_push    = 1'b1;
                            o_op.kind = rlbd_pkg::OP_RUN;
                        end
                        n_rem   = '0;
                        n_phase = PH_CTRL;
                    end
                    default: n_phase = PH_STOP;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CTRL;
            r_mode  <= '0;
            r_rem   <= '0;
        end else begin
            r_phase <= n_phase;
            r_mode  <= n_mode;
            r_rem   <= n_rem;
        end
    end

endmodule

// ----- hdl/rlbd_fifo.sv -----
`timescale 1ns / 1ps
// Command queue between the parser and the executor.
// Depends on rlbd_pkg.
module rlbd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  rlbd_pkg::t_op          i_op,
    input  logic                   i_pop,
    output rlbd_pkg::t_op          o_op,
    output rlbd_pkg::t_fifo_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rlbd_pkg::t_op     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;
    logic              do_push, do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_op    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/rlbd_back.sv -----
`timescale 1ns / 1ps
// Executor: runs queued commands against the 256-byte history, checks the
// output limit and distances, and drives the registered result stage.
// Depends on rlbd_pkg.
module rlbd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rlbd_pkg::t_op                 i_op,
    input  rlbd_pkg::t_fifo_status        i_fifo,
    output logic                          o_pop,
    input  logic [rlbd_pkg::BW_W-1:0]     i_limit,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rlbd_pkg::BYTE_W-1:0]   o_byte,
    output logic [rlbd_pkg::CNT_W-1:0]    o_count,
    output logic [rlbd_pkg::ST_W-1:0]     o_status,
    output logic                          o_last
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RUN    = 8'b0000_0010,
        S_FILL   = 8'b0000_0100,
        S_RUNOUT = 8'b0000_1000,
        S_CRD    = 8'b0001_0000,
        S_CWR    = 8'b0010_0000,
        S_FAIL   = 8'b0100_0000,
        S_STOP   = 8'b1000_0000
    } t_state;

    localparam int HIST_DEPTH = 1 << rlbd_pkg::HIST_AW;

    t_state                             r_state, n_state;
    logic [rlbd_pkg::BW_W-1:0]          r_bw, n_bw;
    logic [rlbd_pkg::BYTE_W-1:0]        r_byte, n_byte;
    logic [rlbd_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic [rlbd_pkg::CNT_W-1:0]         r_take, n_take;
    logic                               r_short, n_short;
    logic [rlbd_pkg::ST_W-1:0]          r_fail, n_fail;
    logic [rlbd_pkg::BYTE_W-1:0]        r_rdata;

    logic [rlbd_pkg::BYTE_W-1:0]        r_hist [HIST_DEPTH];
    logic                               mem_we, mem_re;
    logic [rlbd_pkg::HIST_AW-1:0]       mem_ra;
    logic [rlbd_pkg::BYTE_W-1:0]        mem_wd;

    logic                               r_out_valid;
    logic [rlbd_pkg::BYTE_W-1:0]        r_out_byte;
    logic [rlbd_pkg::CNT_W-1:0]         r_out_cnt;
    logic [rlbd_pkg::ST_W-1:0]          r_out_st;
    logic                               r_out_last;

    logic                               out_free, emit, e_last;
    logic [rlbd_pkg::BYTE_W-1:0]        e_byte;
    logic [rlbd_pkg::CNT_W-1:0]         e_cnt;
    logic [rlbd_pkg::ST_W-1:0]          e_st;
    logic                               bw_full;
    logic [rlbd_pkg::BW_W-1:0]          room;
    logic [rlbd_pkg::CNT_W-1:0]         take;

    assign out_free = !r_out_valid || i_ready;
    assign bw_full  = (r_bw >= i_limit);
    assign room     = i_limit - r_bw;
    assign take     = bw_full ? '0 :
                      (room < rlbd_pkg::BW_W'(r_cnt)) ? room[rlbd_pkg::CNT_W-1:0] : r_cnt;
    // copy source; distance is at most 255 so the low bits wrap correctly
    assign mem_ra   = r_bw[rlbd_pkg::HIST_AW-1:0] - r_byte;

    always_comb begin
        n_state = r_state;
        n_bw    = r_bw;
        n_byte  = r_byte;
        n_cnt   = r_cnt;
        n_take  = r_take;
        n_short = r_short;
        n_fail  = r_fail;
        o_pop   = 1'b0;
        emit    = 1'b0;
        e_byte  = '0;
        e_cnt   = rlbd_pkg::CNT_W'(1);
        e_st    = rlbd_pkg::ST_DATA;
        e_last  = 1'b1;
        mem_we  = 1'b0;
        mem_wd  = r_byte;
        mem_re  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_fifo.empty) begin
                    unique case (i_op.kind)
                        rlbd_pkg::OP_END: begin
                            if (out_free) begin
                                o_pop   = 1'b1;
                                emit    = 1'b1;
                                e_st    = rlbd_pkg::ST_END;
                                n_state = S_STOP;
                            end
                        end
                        rlbd_pkg::OP_SHORT: begin
                            if (out_free) begin
                                o_pop   = 1'b1;
                                emit    = 1'b1;
                                e_st    = rlbd_pkg::ST_SHORT;
                                n_state = S_STOP;
                            end
                        end
                        rlbd_pkg::OP_LIT: begin
                            if (out_free) begin
                                o_pop = 1'b1;
                                emit  = 1'b1;
                                if (bw_full) begin
                                    e_st    = rlbd_pkg::ST_LIMIT;
                                    n_state = S_STOP;
                                end else begin
                                    e_byte = i_op.data;
                                    mem_we = 1'b1;
                                    mem_wd = i_op.data;
                                    n_bw   = r_bw + 1'b1;
                                end
                            end
                        end
                        rlbd_pkg::OP_RUN: begin
                            o_pop   = 1'b1;
                            n_byte  = i_op.data;
                            n_cnt   = i_op.count;
                            n_state = S_RUN;
                        end
                        rlbd_pkg::OP_COPY: begin
                            o_pop   = 1'b1;
                            n_byte  = i_op.data;
                            n_cnt   = i_op.count;
                            n_state = S_CRD;
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            S_RUN: begin
                n_take  = take;
                n_short = (take != r_cnt);
                n_cnt   = take;
                n_fail  = rlbd_pkg::ST_LIMIT;
                n_state = S_FILL;
            end
            S_FILL: begin
                // one history write per cycle for the part of the run that fits
                if (r_cnt != '0) begin
                    mem_we = 1'b1;
                    n_bw   = r_bw + 1'b1;
                    n_cnt  = r_cnt - 1'b1;
                end else begin
                    n_state = S_RUNOUT;
                end
            end
            S_RUNOUT: begin
                if (r_take == '0) begin
                    n_state = S_FAIL;
                end else if (out_free) begin
                    emit    = 1'b1;
                    e_byte  = r_byte;
                    e_cnt   = r_take;
                    e_last  = !r_short;
                    n_state = r_short ? S_FAIL : S_IDLE;
                end
            end
            S_CRD: begin
                if (r_byte == '0 || rlbd_pkg::BW_W'(r_byte) >= r_bw) begin
                    n_fail  = rlbd_pkg::ST_DIST;
                    n_state = S_FAIL;
                end else if (bw_full) begin
                    n_fail  = rlbd_pkg::ST_LIMIT;
                    n_state = S_FAIL;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_CWR;
                end
            end
            S_CWR: begin
                if (out_free) begin
                    mem_we  = 1'b1;
                    mem_wd  = r_rdata;
                    emit    = 1'b1;
                    e_byte  = r_rdata;
                    e_last  = (r_cnt == rlbd_pkg::CNT_W'(1));
                    n_bw    = r_bw + 1'b1;
                    n_cnt   = r_cnt - 1'b1;
                    n_state = e_last ? S_IDLE : S_CRD;
                end
            end
            S_FAIL: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_st    = r_fail;
                    n_state = S_STOP;
                end
            end
            S_STOP: begin
                // drain whatever the parser still queues
                o_pop = !i_fifo.empty;
            end
            default: n_state = S_STOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[r_bw[rlbd_pkg::HIST_AW-1:0]] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_hist[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bw    <= n_bw;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_cnt   <= n_cnt;
        r_take  <= n_take;
        r_short <= n_short;
        r_fail  <= n_fail;
        if (emit) begin
            r_out_byte <= e_byte;
            r_out_cnt  <= e_cnt;
            r_out_st   <= e_st;
            r_out_last <= e_last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_byte   = r_out_byte;
    assign o_count  = r_out_cnt;
    assign o_status = r_out_st;
    assign o_last   = r_out_last;

endmodule

// ----- hdl/rle_lz_byte_decompressor_core.sv -----
`timescale 1ns / 1ps
// Top level of the RLE / back-reference byte decompressor: register port,
// parser, command queue and executor. Depends on rlbd_pkg, rlbd_front,
// rlbd_fifo, rlbd_back.
//
//  port group   | dir | payload
//  -------------+-----+-----------------------------------------------------
//  s_axis       | in  | tdata: in_byte[7:0]; tlast: in_last
//  m_axis       | out | tdata: out_byte[7:0], repeat_count[14:8]; tuser: status; tlast
//  apb (p*)     | in  | reg 0 at 0x0: output_limit[23:0]
//
// Control, literal and distance bytes are taken one per cycle while the queue has room.
// In the executor a literal is handled from idle, a run of n fitting bytes is written to history
// (one history write per byte) and then emitted once, a copy does a registered history read per byte.
// Input stalls only when the QUEUE_DEPTH-entry command queue is full; output stalls
// hold the executor. Reset is synchronous; history needs no clearing pass.
module rle_lz_byte_decompressor_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // s_axis tdata: in_byte[7:0]
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,
    input  logic                             i_s_axis_tlast,
    // m_axis tdata: out_byte[7:0], repeat_count[14:8], zero[15]
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [15:0]                      o_m_axis_tdata,
    // m_axis tuser: status[2:0]
    output logic [2:0]                       o_m_axis_tuser,
    output logic                             o_m_axis_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rlbd_pkg::ADDR_W-1:0]      paddr,
    input  logic [rlbd_pkg::DATA_W-1:0]      pwdata,
    output logic [rlbd_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);

    logic [rlbd_pkg::BW_W-1:0]   r_output_limit;
    logic                        reg_sel, reg_wr;
    logic                        push, pop;
    rlbd_pkg::t_op               push_op, head_op;
    rlbd_pkg::t_fifo_status      fifo_st;
    logic [rlbd_pkg::CNT_W-1:0]  out_cnt;
    logic [rlbd_pkg::BYTE_W-1:0] out_byte;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[rlbd_pkg::ADDR_W-1:2] == rlbd_pkg::REG_OUTPUT_LIMIT);
    assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? rlbd_pkg::DATA_W'(r_output_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_limit <= rlbd_pkg::LIMIT_RESET;
        end else if (reg_wr) begin
            r_output_limit <= pwdata[rlbd_pkg::BW_W-1:0];
        end
    end

    rlbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_fifo  (fifo_st),
        .o_push  (push),
        .o_op    (push_op)
    );

    rlbd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (push_op),
        .i_pop    (pop),
        .o_op     (head_op),
        .o_status (fifo_st)
    );

    rlbd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (head_op),
        .i_fifo   (fifo_st),
        .o_pop    (pop),
        .i_limit  (r_output_limit),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_byte   (out_byte),
        .o_count  (out_cnt),
        .o_status (o_m_axis_tuser),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, out_cnt, out_byte};

endmodule

// ----- hdl/rlbd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the decompressor core, bound to the top level.
// Depends on rlbd_pkg and rle_lz_byte_decompressor_core.
module rlbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_data,
    input logic [2:0]  i_out_user,
    input logic        i_out_last
);

    logic r_stopped;

    // a delivered status result ends the stream until reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_out_user != rlbd_pkg::ST_DATA) begin
            r_stopped <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data)
            && $stable(i_out_user) && $stable(i_out_last))
        else $error("result changed while stalled");

    a_silent_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> !i_out_valid)
        else $error("result after end or error");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_user != rlbd_pkg::ST_DATA |->
            i_out_last && i_out_data[7:0] == 8'd0 && i_out_data[14:8] == 7'd1)
        else $error("malformed status result");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_user == rlbd_pkg::ST_DATA |->
            i_out_data[14:8] != 7'd0 && !i_out_data[15])
        else $error("data result with zero count");

endmodule

bind rle_lz_byte_decompressor_core rlbd_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_m_axis_tvalid),
    .i_out_ready (i_m_axis_tready),
    .i_out_data  (o_m_axis_tdata),
    .i_out_user  (o_m_axis_tuser),
    .i_out_last  (o_m_axis_tlast)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rle_lz_byte_decompressor_core: feeds one compressed
// stream on s_axis, predicts every m_axis result and compares field by field.
// Depends on rlbd_pkg and the core RTL.
module testbench;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int SETTLE_CYCLES   = 64;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PHASE_ITEMS     = 145;
    localparam int POST_STOP_ITEMS = 6;
    localparam logic [rlbd_pkg::ADDR_W-1:0] LIMIT_ADDR = {rlbd_pkg::REG_OUTPUT_LIMIT, 2'b00};

    typedef enum logic [1:0] {WAIT_CTRL, WAIT_OPERAND, WAIT_LITERAL, HALTED} t_parse;
    typedef enum logic [1:0] {FIN_END, FIN_SHORT, FIN_LIMIT, FIN_DIST} t_finale;

    typedef struct packed {
        logic [rlbd_pkg::BYTE_W-1:0] data;
        logic [rlbd_pkg::CNT_W-1:0]  reps;
        logic [rlbd_pkg::ST_W-1:0]   status;
        logic                        last;
    } t_result;

    typedef struct packed {
        logic [rlbd_pkg::BYTE_W-1:0] code;
        logic                        typed;
        t_result                     result;
    } t_row;

    localparam t_result NO_RESULT = '0;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [7:0]                    i_s_axis_tdata  = '0;   // in_byte[7:0]
    logic                          i_s_axis_tlast  = 1'b0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [15:0]                   o_m_axis_tdata;         // out_byte[7:0], repeat_count[14:8]
    logic [2:0]                    o_m_axis_tuser;         // status[2:0]
    logic                          o_m_axis_tlast;
    logic                          psel            = 1'b0;
    logic                          penable         = 1'b0;
    logic                          pwrite          = 1'b0;
    logic [rlbd_pkg::ADDR_W-1:0]   paddr           = '0;
    logic [rlbd_pkg::DATA_W-1:0]   pwdata          = '0;
    logic [rlbd_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // decoder state as the block should hold it
    logic [rlbd_pkg::BYTE_W-1:0]   window [256];
    logic [rlbd_pkg::BW_W-1:0]     produced;
    logic [rlbd_pkg::BW_W-1:0]     limit_model;
    t_parse                        parse_state;
    logic [1:0]                    cmd_mode;
    logic [rlbd_pkg::CNT_W-1:0]    owed;

    t_result               step_out [$];
    t_result               pending [$];

    int fault_count   = 0;
    int fed_count     = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_left     = 0;
    int quiet_run     = 0;

    t_row directed_rows [23] = '{
        '{8'h81, 1'b0, NO_RESULT},                            // literal x1
        '{8'hFF, 1'b1, '{8'hFF, 7'd1, rlbd_pkg::ST_DATA, 1'b1}},
        '{8'h80, 1'b0, NO_RESULT},                            // empty literal
        '{8'hC0, 1'b0, NO_RESULT},                            // empty copy, distance 0 ok
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h7F, 1'b0, NO_RESULT},                            // longest run
        '{8'h00, 1'b1, '{8'h00, 7'd127, rlbd_pkg::ST_DATA, 1'b1}},
        '{8'h01, 1'b0, NO_RESULT},
        '{8'hA5, 1'b1, '{8'hA5, 7'd1, rlbd_pkg::ST_DATA, 1'b1}},
        '{8'h40, 1'b0, NO_RESULT},                            // run, mode bits 01
        '{8'h5A, 1'b1, '{8'h5A, 7'd64, rlbd_pkg::ST_DATA, 1'b1}},
        '{8'h83, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'h7F, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},                            // copy 63 at distance 1
        '{8'h01, 1'b0, NO_RESULT},
        '{8'hC4, 1'b0, NO_RESULT},                            // farthest distance
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hC2, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, NO_RESULT},
        '{8'h3F, 1'b0, NO_RESULT},
        '{8'hC3, 1'b1, '{8'hC3, 7'd63, rlbd_pkg::ST_DATA, 1'b1}}
    };

    rle_lz_byte_decompressor_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    function automatic void emit_result(input logic [rlbd_pkg::BYTE_W-1:0] data,
                                        input logic [rlbd_pkg::CNT_W-1:0] reps,
                                        input logic [rlbd_pkg::ST_W-1:0] status);
        step_out.push_back(t_result'{data, reps, status, 1'b0});
    endfunction

    function automatic void halt_on(input logic [rlbd_pkg::ST_W-1:0] status);
        emit_result('0, 7'd1, status);
        parse_state = HALTED;
    endfunction

    function automatic void store_byte(input logic [rlbd_pkg::BYTE_W-1:0] v);
        window[produced[rlbd_pkg::HIST_AW-1:0]] = v;
        produced = produced + 1'b1;
    endfunction

    // Work out the results of one accepted compressed byte and queue them.
    function automatic void decode_byte(input logic [rlbd_pkg::BYTE_W-1:0] code,
                                        input logic tail);
        int          room;
        int          take;
        int          left;
        int          i;
        logic [7:0]  v;
        t_result     closing;
        step_out.delete();
        if (parse_state == HALTED)
            return;
        if (parse_state == WAIT_CTRL && code == 8'h00) begin
            emit_result('0, 7'd1, rlbd_pkg::ST_END);
            parse_state = HALTED;
        end else if (tail) begin
            halt_on(rlbd_pkg::ST_SHORT);
        end else if (parse_state == WAIT_CTRL) begin
            cmd_mode = code[7:rlbd_pkg::MODE_SHIFT];
            if (cmd_mode == rlbd_pkg::MODE_LIT) begin
                owed = rlbd_pkg::CNT_W'(code[rlbd_pkg::LIT_CNT_W-1:0]);
                if (owed != 0)
                    parse_state = WAIT_LITERAL;
            end else if (cmd_mode == rlbd_pkg::MODE_COPY) begin
                owed = rlbd_pkg::CNT_W'(code[rlbd_pkg::LIT_CNT_W-1:0]);
                parse_state = WAIT_OPERAND;
            end else begin
                owed = code[rlbd_pkg::CNT_W-1:0];
                parse_state = WAIT_OPERAND;
            end
        end else if (parse_state == WAIT_LITERAL) begin
            if (produced >= limit_model) begin
                halt_on(rlbd_pkg::ST_LIMIT);
            end else begin
                store_byte(code);
                emit_result(code, 7'd1, rlbd_pkg::ST_DATA);
                owed = owed - 1'b1;
                if (owed == 0)
                    parse_state = WAIT_CTRL;
            end
        end else if (cmd_mode != rlbd_pkg::MODE_COPY) begin
            // a run cut at the limit still reports the part that fits
            room = (limit_model > produced) ? int'(limit_model - produced) : 0;
            take = (room < int'(owed)) ? room : int'(owed);
            for (i = 0; i < take; i++)
                store_byte(code);
            if (take != 0)
                emit_result(code, rlbd_pkg::CNT_W'(take), rlbd_pkg::ST_DATA);
            parse_state = WAIT_CTRL;
            if (take < int'(owed))
                halt_on(rlbd_pkg::ST_LIMIT);
            owed = '0;
        end else begin
            left = int'(owed);
            owed = '0;
            parse_state = WAIT_CTRL;
            while (left != 0) begin
                if (code == 8'h00 || rlbd_pkg::BW_W'(code) >= produced) begin
                    halt_on(rlbd_pkg::ST_DIST);
                    break;
                end
                if (produced >= limit_model) begin
                    halt_on(rlbd_pkg::ST_LIMIT);
                    break;
                end
                v = window[rlbd_pkg::HIST_AW'(produced - rlbd_pkg::BW_W'(code))];
                store_byte(v);
                emit_result(v, 7'd1, rlbd_pkg::ST_DATA);
                left--;
            end
        end
        if (step_out.size() != 0) begin
            closing = step_out.pop_back();
            closing.last = 1'b1;
            step_out.push_back(closing);
        end
        foreach (step_out[j])
            pending.push_back(step_out[j]);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            fault_count++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    // hand-written rows must agree with the predictor
    function automatic void confirm_typed(input t_result want);
        if (step_out.size() != 1 || step_out[0] !== want) begin
            fault_count++;
            $display("%0t: typed result expected %h, predictor gave %0d results",
                     $time, want, step_out.size());
        end
    endfunction

    task automatic push_byte(input logic [rlbd_pkg::BYTE_W-1:0] code, input logic tail);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= code;
        i_s_axis_tlast  <= tail;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        decode_byte(code, tail);
        fed_count++;
    endtask

    task automatic feed_command(input rlbd_pkg::t_op_kind kind, input int count);
        int span;
        int k;
        case (kind)
            rlbd_pkg::OP_RUN: begin
                push_byte({1'b0, rlbd_pkg::CNT_W'(count)}, 1'b0);
                push_byte(8'($urandom), 1'b0);
            end
            rlbd_pkg::OP_LIT: begin
                push_byte({rlbd_pkg::MODE_LIT, rlbd_pkg::LIT_CNT_W'(count)}, 1'b0);
                for (k = 0; k < count && parse_state != HALTED; k++)
                    push_byte(8'($urandom), 1'b0);
            end
            default: begin
                span = (produced > 255) ? 255 : int'(produced) - 1;
                push_byte({rlbd_pkg::MODE_COPY, rlbd_pkg::LIT_CNT_W'(count)}, 1'b0);
                // an empty copy takes any distance; short ones overlap their own output
                if (count == 0)
                    push_byte(8'($urandom), 1'b0);
                else if ($urandom_range(3) == 0)
                    push_byte(8'($urandom_range((span < 4) ? span : 4, 1)), 1'b0);
                else
                    push_byte(8'($urandom_range(span, 1)), 1'b0);
            end
        endcase
    endtask

    task automatic random_command();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            feed_command(rlbd_pkg::OP_RUN, ($urandom_range(9) == 0) ? $urandom_range(127, 1)
                                                                    : $urandom_range(16, 1));
        else if (pick < 65)
            feed_command(rlbd_pkg::OP_LIT, ($urandom_range(7) == 0) ? $urandom_range(63)
                                                                    : $urandom_range(6));
        else
            feed_command(rlbd_pkg::OP_COPY, ($urandom_range(7) == 0) ? $urandom_range(63)
                                                                     : $urandom_range(6));
    endtask

    // stop requests, wait for every expected result, then let queued commands finish
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [rlbd_pkg::DATA_W-1:0] wdata,
                              output logic [rlbd_pkg::DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LIMIT_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_limit_reg();
        logic [rlbd_pkg::DATA_W-1:0] readback;
        apb_access(1'b0, '0, readback);
        if (readback[rlbd_pkg::BW_W-1:0] !== limit_model) begin
            fault_count++;
            $display("%0t: output_limit expected 0x%0h, got 0x%0h",
                     $time, limit_model, readback[rlbd_pkg::BW_W-1:0]);
        end
    endtask

    task automatic set_limit(input logic [rlbd_pkg::BW_W-1:0] value);
        logic [rlbd_pkg::DATA_W-1:0] unused;
        apb_access(1'b1, rlbd_pkg::DATA_W'(value), unused);
        limit_model = value;
        check_limit_reg();
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{o_m_axis_tdata[7:0], o_m_axis_tdata[14:8], o_m_axis_tuser, o_m_axis_tlast};
            if (pending.size() == 0) begin
                fault_count++;
                $display("%0t: no result expected, got %h", $time, got);
            end else begin
                want = pending.pop_front();
                check_field("out_byte", want.data, got.data);
                check_field("repeat_count", 8'(want.reps), 8'(got.reps));
                check_field("status", 8'(want.status), 8'(got.status));
                check_field("out_last", 8'(want.last), 8'(got.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || psel) begin
            quiet_run <= 0;
        end else if (quiet_run >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_run <= quiet_run + 1;
        end
    end

    initial begin
        t_finale finale;
        int      margin;
        int      pick;
        int      n;
        produced      = '0;
        limit_model   = rlbd_pkg::LIMIT_RESET;
        parse_state   = WAIT_CTRL;
        cmd_mode      = '0;
        owed          = '0;
        src_idle_pct  = 27;
        sink_idle_pct = 65;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_limit_reg();

        foreach (directed_rows[r]) begin
            push_byte(directed_rows[r].code, 1'b0);
            if (directed_rows[r].typed)
                confirm_typed(directed_rows[r].result);
        end
        while (fed_count < PHASE_ITEMS)
            random_command();
        settle();

        set_limit(rlbd_pkg::BW_W'($urandom_range(24'hFF_FFFE, 24'h10_0000)));
        src_idle_pct  = 65;
        sink_idle_pct = 27;
        while (fed_count < 2 * PHASE_ITEMS)
            random_command();
        settle();

        // long output hold-off while requests keep coming, so the input backs up
        set_limit(rlbd_pkg::LIMIT_RESET);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_left <= HOLD_CYCLES;
        while (fed_count < 3 * PHASE_ITEMS)
            random_command();
        settle();

        // the stream can stop only once, so one way of stopping is drawn per run
        finale = t_finale'($urandom_range(3));
        case (finale)
            FIN_END: begin
                push_byte(8'h00, 1'($urandom_range(1)));
                confirm_typed(t_result'{8'h00, 7'd1, rlbd_pkg::ST_END, 1'b1});
            end
            FIN_SHORT: begin
                push_byte(8'($urandom_range(255, 1)), 1'b1);
                confirm_typed(t_result'{8'h00, 7'd1, rlbd_pkg::ST_SHORT, 1'b1});
            end
            FIN_DIST: begin
                push_byte({rlbd_pkg::MODE_COPY, rlbd_pkg::LIT_CNT_W'($urandom_range(63, 1))},
                          1'b0);
                push_byte(8'h00, 1'b0);
                confirm_typed(t_result'{8'h00, 7'd1, rlbd_pkg::ST_DIST, 1'b1});
            end
            default: begin
                margin = $urandom_range(3);
                set_limit(produced + rlbd_pkg::BW_W'(margin));
                pick = $urandom_range(2);
                feed_command((pick == 0) ? rlbd_pkg::OP_RUN :
                             (pick == 1) ? rlbd_pkg::OP_LIT : rlbd_pkg::OP_COPY,
                             margin + 1 + $urandom_range(4));
            end
        endcase
        settle();

        // stopped: bytes are swallowed without results
        set_limit(24'd1);
        for (n = 0; n < POST_STOP_ITEMS; n++)
            push_byte(8'($urandom), (n == 0) ? 1'b1 : 1'($urandom_range(1)));
        settle();

        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
